// ----- rtl/ntbe_pkg.sv -----
// ----------------------------------------------------------------------------
// ntbe_pkg
// Shared types, codes and code-word helpers of the token bit encoder.
// ----------------------------------------------------------------------------
package ntbe_pkg;

    localparam int OFFSET_BITS_DEF   = 20;
    localparam int LENGTH_BITS_DEF   = 12;
    localparam int OUT_ADDR_BITS_DEF = 24;
    localparam int QUEUE_DEPTH       = 4;
    localparam int WORD_BITS         = 32;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LEN_LOW  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFF_LOW  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEN_EXT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CODE_SEL = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFF_BIAS = 3'd4;

    localparam logic [1:0] KIND_LIT   = 2'd0;
    localparam logic [1:0] KIND_MATCH = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [31:0] THR_SS11 = 32'h0000_0d00;
    localparam logic [31:0] THR_SS12 = 32'h0000_0500;

    // offset low bits value that means "send a whole byte"
    localparam logic [3:0] OFF_LOW_BYTE = 4'd8;

    typedef enum logic [4:0] {
        OP_BITS  = 5'b00001,
        OP_BYTE  = 5'b00010,
        OP_FIRST = 5'b00100,
        OP_SKIP  = 5'b01000,
        OP_PAD   = 5'b10000
    } t_op_code;

    typedef struct packed {
        t_op_code    code;
        logic [31:0] val;
        logic [5:0]  nbits;
        logic        eot;
    } t_op;

    // base subtracted by the ss12 prefix after n groups: binary 1010..10
    function automatic logic [32:0] ss12_base(input logic [5:0] n);
        logic [32:0] s;
        s = '0;
        for (int k = 0; k < 16; k++) begin
            if (6'(k) < n) s[2*k+1] = 1'b1;
        end
        return s;
    endfunction

    function automatic logic [5:0] msb_index(input logic [32:0] j);
        logic [5:0] m;
        m = '0;
        for (int k = 0; k < 33; k++) begin
            if (j[k]) m = 6'(k);
        end
        return m;
    endfunction

    // data bits of j interleaved with continuation flags, stop flag last
    function automatic logic [63:0] ss11_word(input logic [32:0] j);
        logic [63:0] w;
        w = '0;
        for (int k = 0; k < 32; k++) begin
            w[2*k+1] = j[k];
            w[2*k]   = (k == 0);
        end
        return w;
    endfunction

    function automatic logic [63:0] ss12_word(input logic [32:0] ip);
        logic [63:0] w;
        w    = '0;
        w[1] = ip[0];
        w[0] = 1'b1;
        for (int k = 1; k <= 16; k++) begin
            w[3*k-1] = ip[2*k-1];
            w[3*k+1] = ip[2*k];
        end
        return w;
    endfunction

endpackage

// ----- rtl/ntbe_front.sv -----
// ----------------------------------------------------------------------------
// ntbe_front
// Accepts tokens, holds the configuration and breaks each token into
// packer operations (bit groups, bytes, address skips, padding).
// ----------------------------------------------------------------------------
module ntbe_front
    import ntbe_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_token_kind,
    input  logic [7:0]               i_literal_byte,
    input  logic [OFFSET_BITS-1:0]   i_match_offset,
    input  logic [LENGTH_BITS-1:0]   i_match_length,
    output logic                     o_push,
    output t_op                      o_op,
    input  logic                     i_full
);

    localparam int TW = LENGTH_BITS + 9;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_HEAD = 11'b00000000010,
        S_LITB = 11'b00000000100,
        S_PN   = 11'b00000001000,
        S_PW   = 11'b00000010000,
        S_PHI  = 11'b00000100000,
        S_PLO  = 11'b00001000000,
        S_OLOW = 11'b00010000000,
        S_LEN  = 11'b00100000000,
        S_LRAW = 11'b01000000000,
        S_PAD  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic [2:0] r_p1;
    logic [3:0] r_p2;
    logic [2:0] r_p3;
    logic [1:0] r_cs;
    logic       r_bias;

    logic [1:0]             r_kind;
    logic [7:0]             r_lit;
    logic [OFFSET_BITS-1:0] r_off, r_last_off, n_last_off;
    logic [LENGTH_BITS-1:0] r_len;
    logic                   r_first, n_first;
    logic                   r_which, n_which;   // 0 offset prefix, 1 length prefix
    logic [31:0]            r_m, n_m;
    logic [32:0]            r_p, n_p;
    logic [32:0]            r_j, n_j;
    logic [5:0]             r_n, n_n;
    logic [63:0]            r_w, n_w;
    logic [6:0]             r_wl, n_wl;
    logic [LENGTH_BITS-1:0] r_uv, n_uv;

    logic                   accept;
    logic [31:0]            m_c;
    logic [32:0]            p_c;
    logic                   sel11;
    logic [32:0]            j11;
    logic [32:0]            ip12;
    logic [5:0]             n12;
    logic                   adj;
    logic signed [TW-1:0]   t_len, lim, v_len;
    logic                   short_len;
    logic [LENGTH_BITS-1:0] uv_c;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready && (i_token_kind != KIND_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1   <= 3'd0;
            r_p2   <= 4'd8;
            r_p3   <= 3'd0;
            r_cs   <= 2'd0;
            r_bias <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LEN_LOW:  r_p1   <= i_cfg_data[2:0];
                CFG_OFF_LOW:  r_p2   <= i_cfg_data[3:0];
                CFG_LEN_EXT:  r_p3   <= i_cfg_data[2:0];
                CFG_CODE_SEL: r_cs   <= i_cfg_data[1:0];
                CFG_OFF_BIAS: r_bias <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_token_kind;
            r_lit  <= i_literal_byte;
            r_off  <= i_match_offset;
            r_len  <= i_match_length;
        end
        r_m  <= n_m;
        r_p  <= n_p;
        r_j  <= n_j;
        r_n  <= n_n;
        r_w  <= n_w;
        r_wl <= n_wl;
        r_uv <= n_uv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_first    <= 1'b1;
            r_last_off <= OFFSET_BITS'(1);
            r_which    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_first    <= n_first;
            r_last_off <= n_last_off;
            r_which    <= n_which;
        end
    end

    // coded offset and its prefix value (end token codes offset zero)
    always_comb begin
        m_c = ((r_kind == KIND_END) ? 32'd0 : 32'(r_off)) - 32'(r_bias);
        p_c = {1'b0, 32'(m_c >> r_p2) + 32'd1};
    end

    always_comb begin
        sel11 = r_which ? r_cs[1] : r_cs[0];
        j11   = r_p + 33'd2;
        n12   = '0;
        for (int k = 1; k <= 16; k++) begin
            if (r_p >= ss12_base(6'(k))) n12 = 6'(k);
        end
        ip12  = r_j - ss12_base(r_n);
    end

    always_comb begin
        adj       = 32'(r_off) > (r_cs[0] ? THR_SS11 : THR_SS12);
        t_len     = $signed(TW'(r_len)) - $signed(TW'(1)) - $signed(TW'(adj));
        lim       = $signed(TW'(1) << r_p1);
        short_len = (r_p1 != 3'd0) && (t_len >= $signed(TW'(1))) && (t_len < lim);
        v_len     = t_len - lim;
        uv_c      = v_len[TW-1] ? '0 : v_len[LENGTH_BITS-1:0];
    end

    always_comb begin
        n_state    = r_state;
        n_first    = r_first;
        n_last_off = r_last_off;
        n_which    = r_which;
        n_m        = r_m;
        n_p        = r_p;
        n_j        = r_j;
        n_n        = r_n;
        n_w        = r_w;
        n_wl       = r_wl;
        n_uv       = r_uv;
        o_push     = 1'b0;
        o_op       = '{code: OP_BITS, val: 32'd0, nbits: 6'd0, eot: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_HEAD;
            end
            S_HEAD: begin
                o_push = 1'b1;
                if (!i_full) begin
                    if (r_first) begin
                        n_first = 1'b0;
                        if (r_kind == KIND_LIT) begin
                            o_op    = '{code: OP_FIRST, val: 32'(r_lit), nbits: 6'd0,
                                        eot: 1'b1};
                            n_state = S_IDLE;
                        end else begin
                            o_op = '{code: OP_SKIP, val: 32'd0, nbits: 6'd0, eot: 1'b0};
                        end
                    end else if (r_kind == KIND_LIT) begin
                        o_op    = '{code: OP_BITS, val: 32'd1, nbits: 6'd1, eot: 1'b0};
                        n_state = S_LITB;
                    end else if (r_kind == KIND_MATCH && r_off == r_last_off) begin
                        // repeated offset: 0 then 0,1
                        o_op    = '{code: OP_BITS, val: 32'd1, nbits: 6'd3, eot: 1'b0};
                        n_state = S_LEN;
                    end else begin
                        o_op    = '{code: OP_BITS, val: 32'd0, nbits: 6'd1, eot: 1'b0};
                        if (r_kind == KIND_MATCH) n_last_off = r_off;
                        n_m     = m_c;
                        n_p     = p_c;
                        n_which = 1'b0;
                        n_state = S_PN;
                    end
                end
            end
            S_LITB: begin
                o_push = 1'b1;
                o_op   = '{code: OP_BYTE, val: 32'(r_lit), nbits: 6'd0, eot: 1'b1};
                if (!i_full) n_state = S_IDLE;
            end
            S_PN: begin
                if (sel11) begin
                    n_j = j11;
                    n_n = msb_index(j11);
                end else begin
                    n_j = r_p;
                    n_n = n12;
                end
                n_state = S_PW;
            end
            S_PW: begin
                if (sel11) begin
                    n_w  = ss11_word(r_j);
                    n_wl = {r_n, 1'b0};
                end else begin
                    n_w  = ss12_word(ip12);
                    n_wl = {r_n, 1'b0} + 7'(r_n) + 7'd2;
                end
                n_state = (n_wl > 7'd32) ? S_PHI : S_PLO;
            end
            S_PHI: begin
                o_push = 1'b1;
                o_op   = '{code: OP_BITS, val: r_w[63:32], nbits: 6'(r_wl - 7'd32),
                           eot: 1'b0};
                if (!i_full) n_state = S_PLO;
            end
            S_PLO: begin
                o_push = 1'b1;
                o_op   = '{code: OP_BITS, val: r_w[31:0],
                           nbits: (r_wl > 7'd32) ? 6'd32 : 6'(r_wl), eot: 1'b0};
                if (!i_full) n_state = r_which ? S_LRAW : S_OLOW;
            end
            S_OLOW: begin
                o_push = 1'b1;
                if (r_p2 == OFF_LOW_BYTE) begin
                    o_op = '{code: OP_BYTE, val: r_m, nbits: 6'd0, eot: 1'b0};
                end else begin
                    o_op = '{code: OP_BITS, val: r_m, nbits: 6'(r_p2), eot: 1'b0};
                end
                if (!i_full) n_state = (r_kind == KIND_END) ? S_PAD : S_LEN;
            end
            S_LEN: begin
                o_push = 1'b1;
                if (short_len) begin
                    o_op = '{code: OP_BITS, val: 32'(t_len[LENGTH_BITS-1:0]),
                             nbits: 6'(r_p1), eot: 1'b1};
                    if (!i_full) n_state = S_IDLE;
                end else begin
                    o_op = '{code: OP_BITS, val: 32'd0, nbits: 6'(r_p1), eot: 1'b0};
                    if (!i_full) begin
                        n_uv    = uv_c;
                        n_p     = 33'(uv_c >> r_p3);
                        n_which = 1'b1;
                        n_state = S_PN;
                    end
                end
            end
            S_LRAW: begin
                o_push = 1'b1;
                o_op   = '{code: OP_BITS, val: 32'(r_uv), nbits: 6'(r_p3), eot: 1'b1};
                if (!i_full) n_state = S_IDLE;
            end
            S_PAD: begin
                o_push = 1'b1;
                o_op   = '{code: OP_PAD, val: 32'd0, nbits: 6'd0, eot: 1'b1};
                if (!i_full) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/ntbe_queue.sv -----
// ----------------------------------------------------------------------------
// ntbe_queue
// Short operation queue between the token front end and the bit packer.
// ----------------------------------------------------------------------------
module ntbe_queue
    import ntbe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op,
    input  logic i_pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_op           r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;
    logic          wr_en, rd_en;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wr] <= i_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wr <= r_wr + PW'(1);
            if (rd_en) r_rd <= r_rd + PW'(1);
            r_cnt <= r_cnt + (PW+1)'(wr_en) - (PW+1)'(rd_en);
        end
    end

endmodule

// ----- rtl/ntbe_back.sv -----
// ----------------------------------------------------------------------------
// ntbe_back
// Bit packer: appends bit groups to the 32-bit flag word, places bytes,
// and issues byte and word writes through a hold and an output register.
// ----------------------------------------------------------------------------
module ntbe_back
    import ntbe_pkg::*;
#(
    parameter int OUT_ADDR_BITS = OUT_ADDR_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  t_op                      i_op,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_write_kind,
    output logic [OUT_ADDR_BITS-1:0] o_address,
    output logic [31:0]              o_write_data,
    output logic                     o_last
);

    localparam int AW = OUT_ADDR_BITS;

    logic [AW-1:0] r_out_addr, n_out_addr;
    logic [AW-1:0] r_word_addr, n_word_addr;
    logic [31:0]   r_word, n_word;
    logic [5:0]    r_cnt, n_cnt;
    logic          r_flush, r_hold_v;
    logic          r_hk;
    logic [AW-1:0] r_ha;
    logic [31:0]   r_hd;
    logic          r_ov, r_ok, r_ol;
    logic [AW-1:0] r_oa;
    logic [31:0]   r_od;

    logic          out_free, busy;
    logic          res_v, res_k;
    logic [AW-1:0] res_a;
    logic [31:0]   res_d;
    logic          push_v, push_last;

    logic          alloc;
    logic [5:0]    c0;
    logic [31:0]   w0;
    logic [AW-1:0] wa0, oa0;
    logic [63:0]   vm, x;
    logic [6:0]    tot, rem;
    logic [63:0]   padw;

    assign out_free = !r_ov || i_out_ready;
    assign busy     = i_valid && !r_flush && out_free;
    assign o_pop    = busy;

    always_comb begin
        alloc = (r_cnt == 6'd32) && (i_op.nbits != 6'd0);
        c0    = alloc ? 6'd0 : r_cnt;
        w0    = alloc ? 32'd0 : r_word;
        wa0   = alloc ? r_out_addr : r_word_addr;
        oa0   = alloc ? (r_out_addr + AW'(4)) : r_out_addr;
        vm    = 64'(i_op.val) & ((64'd1 << i_op.nbits) - 64'd1);
        x     = (64'(w0) << i_op.nbits) | vm;
        tot   = 7'(c0) + 7'(i_op.nbits);
        rem   = tot - 7'd32;
        padw  = 64'(r_word) << (6'd32 - r_cnt);
    end

    always_comb begin
        n_out_addr  = r_out_addr;
        n_word_addr = r_word_addr;
        n_word      = r_word;
        n_cnt       = r_cnt;
        res_v       = 1'b0;
        res_k       = 1'b0;
        res_a       = r_out_addr;
        res_d       = 32'd0;
        if (busy) begin
            unique case (i_op.code)
                OP_BITS: begin
                    n_word_addr = wa0;
                    n_out_addr  = oa0;
                    if (tot <= 7'd32) begin
                        n_word = x[31:0];
                        n_cnt  = 6'(tot);
                        // an empty group never completes a word again
                        if (tot == 7'd32 && i_op.nbits != 6'd0) begin
                            res_v = 1'b1;
                            res_k = 1'b1;
                            res_a = wa0;
                            res_d = x[31:0];
                        end
                    end else begin
                        // word fills part way through the group
                        res_v       = 1'b1;
                        res_k       = 1'b1;
                        res_a       = wa0;
                        res_d       = 32'(x >> rem);
                        n_word      = x[31:0] & 32'((64'd1 << rem) - 64'd1);
                        n_cnt       = 6'(rem);
                        n_word_addr = oa0;
                        n_out_addr  = oa0 + AW'(4);
                    end
                end
                OP_BYTE: begin
                    res_v      = 1'b1;
                    res_d      = {24'd0, i_op.val[7:0]};
                    n_out_addr = r_out_addr + AW'(1);
                end
                OP_FIRST: begin
                    res_v      = 1'b1;
                    res_d      = {24'd0, i_op.val[7:0]};
                    n_out_addr = r_out_addr + AW'(5);
                end
                OP_SKIP: begin
                    n_out_addr = r_out_addr + AW'(5);
                end
                OP_PAD: begin
                    if (r_cnt != 6'd32) begin
                        res_v  = 1'b1;
                        res_k  = 1'b1;
                        res_a  = r_word_addr;
                        res_d  = padw[31:0];
                        n_word = padw[31:0];
                        n_cnt  = 6'd32;
                    end
                end
                default: ;
            endcase
        end
    end

    // the newest write is held back until it is known whether it ends the token
    always_comb begin
        push_v    = 1'b0;
        push_last = 1'b0;
        if (busy && res_v && r_hold_v) begin
            push_v = 1'b1;
        end else if (r_flush && out_free && r_hold_v) begin
            push_v    = 1'b1;
            push_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_addr  <= '0;
            r_word_addr <= AW'(1);
            r_word      <= '0;
            r_cnt       <= '0;
            r_flush     <= 1'b0;
            r_hold_v    <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_out_addr  <= n_out_addr;
            r_word_addr <= n_word_addr;
            r_word      <= n_word;
            r_cnt       <= n_cnt;
            if (busy) begin
                if (res_v) r_hold_v <= 1'b1;
                if (i_op.eot) r_flush <= 1'b1;
            end else if (r_flush && out_free) begin
                r_flush  <= 1'b0;
                r_hold_v <= 1'b0;
            end
            if (out_free) r_ov <= push_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (busy && res_v) begin
            r_hk <= res_k;
            r_ha <= res_a;
            r_hd <= res_d;
        end
        if (out_free && push_v) begin
            r_ok <= r_hk;
            r_oa <= r_ha;
            r_od <= r_hd;
            r_ol <= push_last;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_write_kind = r_ok;
    assign o_address    = r_oa;
    assign o_write_data = r_od;
    assign o_last       = r_ol;

endmodule

// ----- rtl/nrv_token_bit_encoder.sv -----
// ----------------------------------------------------------------------------
// nrv_token_bit_encoder
// Packs a parsed literal/match/end token stream into NRV-style byte and
// 32-bit flag word writes.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  token    in         i_in_valid / o_in_ready   kind, literal, offset, length
//  write    out        o_out_valid / i_out_ready kind, address, data, last
//  config   in         i_cfg_we                  index, data
//
//  Front end takes one token at a time and breaks it into queue ops; a
//  prefix code word wider than 32 bits goes out as two ops. The packer
//  takes one op a cycle while the output register is free and no token
//  end is being flushed, and releases its held write at each token end.
//  A 4-entry op queue and the output register let each side stall alone.
//  Reset is synchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
module nrv_token_bit_encoder
    import ntbe_pkg::*;
#(
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
    parameter int OUT_ADDR_BITS = OUT_ADDR_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_token_kind,
    input  logic [7:0]               i_literal_byte,
    input  logic [OFFSET_BITS-1:0]   i_match_offset,
    input  logic [LENGTH_BITS-1:0]   i_match_length,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_write_kind,
    output logic [OUT_ADDR_BITS-1:0] o_address,
    output logic [31:0]              o_write_data,
    output logic                     o_last
);

    logic push, full, q_valid, pop;
    t_op  push_op, q_op;

    ntbe_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_token_kind   (i_token_kind),
        .i_literal_byte (i_literal_byte),
        .i_match_offset (i_match_offset),
        .i_match_length (i_match_length),
        .o_push         (push),
        .o_op           (push_op),
        .i_full         (full)
    );

    ntbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (full),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (pop)
    );

    ntbe_back #(
        .OUT_ADDR_BITS (OUT_ADDR_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_op         (q_op),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_write_kind (o_write_kind),
        .o_address    (o_address),
        .o_write_data (o_write_data),
        .o_last       (o_last)
    );

endmodule

// ----- rtl/ntbe_checker.sv -----
// ----------------------------------------------------------------------------
// ntbe_checker
// Port-level checks of the token bit encoder, bound to the top level.
// ----------------------------------------------------------------------------
module ntbe_checker
    import ntbe_pkg::*;
#(
    parameter int OUT_ADDR_BITS = OUT_ADDR_BITS_DEF
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_out_ready,
    input logic                     o_out_valid,
    input logic                     o_write_kind,
    input logic [OUT_ADDR_BITS-1:0] o_address,
    input logic [31:0]              o_write_data,
    input logic                     o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("write transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_address) && $stable(o_write_data) && $stable(o_write_kind)
            && $stable(o_last))
        else $error("stalled write transaction changed");

    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_kind |-> o_write_data[31:8] == 24'd0)
        else $error("byte write carries upper data bits");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("write transaction right after reset");

endmodule

bind nrv_token_bit_encoder ntbe_checker #(
    .OUT_ADDR_BITS (OUT_ADDR_BITS)
) u_ntbe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_ready  (i_out_ready),
    .o_out_valid  (o_out_valid),
    .o_write_kind (o_write_kind),
    .o_address    (o_address),
    .o_write_data (o_write_data),
    .o_last       (o_last)
);

// ----- tb/nrv_token_bit_encoder_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrv_token_bit_encoder_checker
// Watches the token, write and config ports of the encoder, predicts the
// packed stream writes for each accepted token and compares them in order.
// ----------------------------------------------------------------------------
module nrv_token_bit_encoder_checker
    import ntbe_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [1:0]               i_token_kind,
    input  logic [7:0]               i_literal_byte,
    input  logic [19:0]              i_match_offset,
    input  logic [11:0]              i_match_length,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic                     i_write_kind,
    input  logic [23:0]              i_address,
    input  logic [31:0]              i_write_data,
    input  logic                     i_last,
    output int                       o_errors,
    output int                       o_pending
);

    typedef struct packed {
        logic        kind;
        logic [23:0] addr;
        logic [31:0] data;
        logic        last;
    } t_write;

    t_write expected_writes[$];
    t_write token_writes[5];
    int     n_token_writes;

    // encoder copy
    int unsigned len_low, off_low, len_ext, code_sel, bias;
    logic [23:0] out_addr, word_addr;
    logic [31:0] bit_word;
    int unsigned bit_cnt;
    logic [19:0] prev_offset;
    logic        first_pending;

    assign o_pending = expected_writes.size();

    function void add_write(logic k, logic [23:0] a, logic [31:0] d);
        if (n_token_writes < 5) begin
            token_writes[n_token_writes] = '{kind: k, addr: a, data: d, last: 1'b0};
            n_token_writes++;
        end
    endfunction

    function void shift_bit(int unsigned b);
        if (bit_cnt == 32) begin
            word_addr = out_addr;
            out_addr  = out_addr + 24'd4;
            bit_word  = '0;
            bit_cnt   = 0;
        end
        bit_word = {bit_word[30:0], b[0]};
        bit_cnt++;
        if (bit_cnt == 32) add_write(1'b1, word_addr, bit_word);
    endfunction

    function void shift_byte(int unsigned v);
        add_write(1'b0, out_addr, {24'd0, v[7:0]});
        out_addr = out_addr + 24'd1;
    endfunction

    function void shift_raw(int unsigned v, int unsigned n);
        for (int unsigned k = 0; k < n; k++) shift_bit(v >> (n - k - 1));
    endfunction

    function void gamma_ss11(longint unsigned i);
        longint unsigned t;
        if (i >= 2) begin
            t = 4;
            i += 2;
            do t <<= 1; while (i >= t);
            t >>= 1;
            do begin
                t >>= 1;
                shift_bit((i & t) != 0);
                shift_bit(0);
            end while (t > 2);
        end
        shift_bit(32'(i & 1));
        shift_bit(1);
    endfunction

    function void gamma_ss12(longint unsigned i);
        longint unsigned t;
        if (i >= 2) begin
            t = 2;
            do begin
                i -= t;
                t <<= 2;
            end while (i >= t);
            do begin
                t >>= 1;
                shift_bit((i & t) != 0);
                shift_bit(0);
                t >>= 1;
                shift_bit((i & t) != 0);
            end while (t > 2);
        end
        shift_bit(32'(i & 1));
        shift_bit(1);
    endfunction

    function void encode_offset(int unsigned m);
        int unsigned p;
        p = 1 + (m >> off_low);
        if (code_sel[0]) gamma_ss11(p);
        else             gamma_ss12(p);
        if (off_low == 8) shift_byte(m);
        else              shift_raw(m, off_low);
    endfunction

    function void encode_match(int unsigned off, int unsigned len);
        int unsigned thr, uv;
        int t, lim, v;
        thr = code_sel[0] ? THR_SS11 : THR_SS12;
        t   = int'(len) - 1 - ((off > thr) ? 1 : 0);
        lim = 1 << len_low;
        shift_bit(0);
        if (off == prev_offset) begin
            shift_bit(0);
            shift_bit(1);
        end else begin
            prev_offset = off[19:0];
            encode_offset(off - bias);
        end
        if (len_low != 0 && t >= 1 && t < lim) begin
            shift_raw(t, len_low);
        end else begin
            v = t - lim;
            shift_raw(0, len_low);
            if (v < 0) v = 0;
            uv = v;
            if (code_sel[1]) gamma_ss11(uv >> len_ext);
            else             gamma_ss12(uv >> len_ext);
            shift_raw(uv, len_ext);
        end
    endfunction

    function void predict_token(logic [1:0] kind, logic [7:0] lit, logic [19:0] off,
                                logic [11:0] len);
        n_token_writes = 0;
        if (kind == KIND_NONE) return;
        if (first_pending) begin
            first_pending = 1'b0;
            if (kind == KIND_LIT) add_write(1'b0, out_addr, {24'd0, lit});
            out_addr = out_addr + 24'd5;
        end else if (kind == KIND_LIT) begin
            shift_bit(1);
            shift_byte(lit);
        end
        if (kind == KIND_MATCH) encode_match(off, len);
        if (kind == KIND_END) begin
            shift_bit(0);
            encode_offset(0 - bias);
            while (bit_cnt != 32) shift_bit(0);
        end
        if (n_token_writes > 0) token_writes[n_token_writes-1].last = 1'b1;
        for (int k = 0; k < n_token_writes; k++) expected_writes.push_back(token_writes[k]);
    endfunction

    always @(posedge i_clk) begin
        t_write exp_w;
        if (!i_rst_n) begin
            len_low       = 0;
            off_low       = 8;
            len_ext       = 0;
            code_sel      = 0;
            bias          = 0;
            out_addr      = '0;
            bit_word      = '0;
            bit_cnt       = 0;
            word_addr     = 24'd1;
            prev_offset   = 20'd1;
            first_pending = 1'b1;
            o_errors      = 0;
            expected_writes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LEN_LOW:  len_low  = i_cfg_data & 7;
                    CFG_OFF_LOW:  off_low  = i_cfg_data & 15;
                    CFG_LEN_EXT:  len_ext  = i_cfg_data & 7;
                    CFG_CODE_SEL: code_sel = i_cfg_data & 3;
                    CFG_OFF_BIAS: bias     = i_cfg_data & 1;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_token(i_token_kind, i_literal_byte, i_match_offset, i_match_length);
            if (i_out_valid && i_out_ready) begin
                if (expected_writes.size() == 0) begin
                    $display("%0t: unexpected write kind %0d addr %h data %h last %0d",
                             $time, i_write_kind, i_address, i_write_data, i_last);
                    o_errors++;
                end else begin
                    exp_w = expected_writes.pop_front();
                    if (exp_w.kind !== i_write_kind) begin
                        $display("%0t: write_kind expected %0d actual %0d",
                                 $time, exp_w.kind, i_write_kind);
                        o_errors++;
                    end
                    if (exp_w.addr !== i_address) begin
                        $display("%0t: address expected %h actual %h",
                                 $time, exp_w.addr, i_address);
                        o_errors++;
                    end
                    if (exp_w.data !== i_write_data) begin
                        $display("%0t: write_data expected %h actual %h",
                                 $time, exp_w.data, i_write_data);
                        o_errors++;
                    end
                    if (exp_w.last !== i_last) begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, exp_w.last, i_last);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/nrv_token_bit_encoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrv_token_bit_encoder_test
// Drives token streams through the encoder under several register settings
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module nrv_token_bit_encoder_test;
    import ntbe_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [1:0]               i_token_kind = '0;
    logic [7:0]               i_literal_byte = '0;
    logic [19:0]              i_match_offset = '0;
    logic [11:0]              i_match_length = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic                     o_write_kind;
    logic [23:0]              o_address;
    logic [31:0]              o_write_data;
    logic                     o_last;

    int          errors, pending;
    int          cycle_cnt = 0;
    int          quiet_cycles = 0;
    int          hold_left = 0;
    bit          steady = 1'b0;
    logic [19:0] recent_offset = 20'd1;

    nrv_token_bit_encoder dut (.*);

    nrv_token_bit_encoder_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_token_kind, .i_literal_byte,
        .i_match_offset, .i_match_length, .i_out_valid(o_out_valid), .i_out_ready,
        .i_write_kind(o_write_kind), .i_address(o_address), .i_write_data(o_write_data),
        .i_last(o_last), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random back-pressure, plus one long hold-off mid run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == 2500) begin
            hold_left   <= 300;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady || ($urandom_range(99) >= 37);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_token(logic [1:0] kind, logic [7:0] lit, logic [19:0] off,
                              logic [11:0] len);
        // idle cycles go with valid low so the last transaction is not offered again
        if (!steady) begin
            while ($urandom_range(99) < 37) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid     <= 1'b1;
        i_token_kind   <= kind;
        i_literal_byte <= lit;
        i_match_offset <= off;
        i_match_length <= len;
        if (kind == KIND_MATCH) recent_offset = off;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [3:0] p1, logic [3:0] p2, logic [3:0] p3,
                             logic [3:0] sel, logic [3:0] b);
        logic [3:0] vals[5];
        vals = '{p1, p2, p3, sel, b};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= k[CFG_IDX_BITS-1:0];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_token();
        int unsigned r;
        logic [19:0] off;
        logic [11:0] len;
        r   = $urandom_range(99);
        off = 20'($urandom >> (12 + $urandom_range(19)));
        if (off == 0 && $urandom_range(9) != 0) off = 1;
        len = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(2, 24));
        if (r < 40)      send_token(KIND_LIT, 8'($urandom), 20'($urandom), 12'($urandom));
        else if (r < 60) send_token(KIND_MATCH, 8'($urandom), recent_offset, len);
        else if (r < 92) send_token(KIND_MATCH, 8'($urandom), off, len);
        else if (r < 97) send_token(KIND_END, 8'($urandom), 20'($urandom), 12'($urandom));
        else             send_token(KIND_NONE, 8'($urandom), 20'($urandom), 12'($urandom));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_cfg(4'd0, OFF_LOW_BYTE, 4'd0, 4'd0, 4'd0);
        // first token a match: address 0 stays unwritten
        send_token(KIND_MATCH, 8'h00, 20'd1, 12'd2);
        send_token(KIND_LIT, 8'hff, 20'hfffff, 12'hfff);
        send_token(KIND_LIT, 8'h00, 20'h00000, 12'h000);
        send_token(KIND_MATCH, 8'h5a, 20'hfffff, 12'hfff);
        send_token(KIND_MATCH, 8'ha5, 20'hfffff, 12'd2);
        send_token(KIND_MATCH, 8'h00, 20'h00d01, 12'd2);
        send_token(KIND_MATCH, 8'h00, 20'h00500, 12'd3);
        send_token(KIND_MATCH, 8'h00, 20'h00501, 12'd1);
        send_token(KIND_MATCH, 8'h00, 20'h00000, 12'd0);
        send_token(KIND_NONE, 8'hff, 20'hfffff, 12'hfff);
        send_token(KIND_END, 8'h00, 20'h0, 12'h0);
        send_token(KIND_LIT, 8'h3c, 20'h0, 12'h0);
        drain();
        write_cfg(4'd7, 4'd15, 4'd7, 4'd3, 4'd1);
        send_token(KIND_MATCH, 8'h00, 20'd1, 12'd5);
        send_token(KIND_MATCH, 8'h00, 20'd0, 12'd100);
        send_token(KIND_MATCH, 8'h00, 20'h00d01, 12'd127);
        send_token(KIND_MATCH, 8'h00, 20'h00d00, 12'd129);
        send_token(KIND_END, 8'h00, 20'h0, 12'h0);
        drain();
        write_cfg(4'd2, 4'd0, 4'd1, 4'd1, 4'd1);
        send_token(KIND_MATCH, 8'h00, 20'd3, 12'd4);
        send_token(KIND_END, 8'h00, 20'h0, 12'h0);
        send_token(KIND_MATCH, 8'h00, 20'd1, 12'd2);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_cfg(4'd0, OFF_LOW_BYTE, 4'd0, 4'd0, 4'd0);
                1: write_cfg(4'd7, 4'd15, 4'd7, 4'd3, 4'd1);
                2: write_cfg(4'd1, 4'd1, 4'd0, 4'd2, 4'd1);
                3: write_cfg(4'd3, 4'd4, 4'd2, 4'd1, 4'd0);
                default: write_cfg(4'($urandom_range(7)), 4'($urandom_range(15)),
                                   4'($urandom_range(7)), 4'($urandom_range(3)),
                                   4'($urandom_range(1)));
            endcase
            steady = (ph == 3);
            for (int k = 0; k < 65; k++) random_token();
            steady = 1'b0;
            drain();
        end

        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
